FILE: src/grid_line_rasterizer_top_assert.svh
// ----------------------------------------------------------------------------
// grid_line_rasterizer_top_assert
// assertion macros for the line rasterizer top level
// ----------------------------------------------------------------------------
`ifndef GRID_LINE_RASTERIZER_TOP_ASSERT_SVH
`define GRID_LINE_RASTERIZER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GLR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define GLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/glr_pkg.sv
// ----------------------------------------------------------------------------
// glr_pkg
// types and constants shared by the line rasterizer modules
// ----------------------------------------------------------------------------
package glr_pkg;

    localparam int GRID_SIZE = 64;

    localparam logic [1:0] REG_GRID_COLS   = 2'd0;
    localparam logic [1:0] REG_GRID_ROWS   = 2'd1;
    localparam logic [1:0] REG_PAINT_COLOR = 2'd2;

    localparam logic [6:0]  GRID_COLS_RST   = 7'd64;
    localparam logic [6:0]  GRID_ROWS_RST   = 7'd64;
    localparam logic [31:0] PAINT_COLOR_RST = 32'hFF0000FF;

    typedef struct packed {
        logic [5:0] start_x;
        logic [5:0] start_y;
        logic [5:0] end_x;
        logic [5:0] end_y;
    } t_segment;

    typedef struct packed {
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic        in_grid;
        logic [11:0] cell_index;
        logic [31:0] cell_color;
        logic        last_cell;
    } t_cell;

    typedef struct packed {
        logic [6:0]  grid_cols;
        logic [6:0]  grid_rows;
        logic [31:0] paint_color;
    } t_cfg;

    typedef struct packed {
        logic [5:0]        cur_x;
        logic [5:0]        cur_y;
        logic signed [7:0] err;
        logic [6:0]        span_dx;
        logic [6:0]        span_dy;
        logic              dir_x;
        logic              dir_y;
    } t_walk;

    typedef struct packed {
        logic [5:0]        nxt_x;
        logic [5:0]        nxt_y;
        logic signed [7:0] nxt_err;
    } t_step;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

endpackage

FILE: src/glr_cfg.sv
// ----------------------------------------------------------------------------
// glr_cfg
// apb register file holding grid size and paint color
// ----------------------------------------------------------------------------
module glr_cfg (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output glr_pkg::t_cfg o_cfg
);
    import glr_pkg::*;

    logic [6:0]  r_grid_cols;
    logic [6:0]  r_grid_rows;
    logic [31:0] r_paint_color;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols   <= GRID_COLS_RST;
            r_grid_rows   <= GRID_ROWS_RST;
            r_paint_color <= PAINT_COLOR_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_GRID_COLS:   r_grid_cols   <= pwdata[6:0];
                REG_GRID_ROWS:   r_grid_rows   <= pwdata[6:0];
                REG_PAINT_COLOR: r_paint_color <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GRID_COLS:   prdata = {25'd0, r_grid_cols};
            REG_GRID_ROWS:   prdata = {25'd0, r_grid_rows};
            REG_PAINT_COLOR: prdata = r_paint_color;
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.grid_cols   = r_grid_cols;
    assign o_cfg.grid_rows   = r_grid_rows;
    assign o_cfg.paint_color = r_paint_color;

endmodule

FILE: src/glr_step.sv
// ----------------------------------------------------------------------------
// glr_step
// shared bresenham step unit: two error compares and one error update per cycle
// ----------------------------------------------------------------------------
module glr_step (
    input  glr_pkg::t_walk i_walk,
    output glr_pkg::t_step o_step
);
    import glr_pkg::*;

    logic signed [8:0] e2;
    logic signed [8:0] dx9;
    logic signed [8:0] dy9;
    logic signed [8:0] err9;
    logic signed [8:0] sum;
    logic              step_x;
    logic              step_y;

    assign e2     = $signed({i_walk.err, 1'b0});
    assign dx9    = $signed({2'b00, i_walk.span_dx});
    assign dy9    = $signed({2'b00, i_walk.span_dy});
    assign err9   = $signed({i_walk.err[7], i_walk.err});
    assign step_x = (e2 >= -dy9);
    assign step_y = (e2 <= dx9);
    assign sum    = err9 - (step_x ? dy9 : 9'sd0) + (step_y ? dx9 : 9'sd0);

    always_comb begin
        o_step.nxt_x   = i_walk.cur_x;
        o_step.nxt_y   = i_walk.cur_y;
        if (step_x) begin
            o_step.nxt_x = i_walk.dir_x ? i_walk.cur_x - 6'd1 : i_walk.cur_x + 6'd1;
        end
        if (step_y) begin
            o_step.nxt_y = i_walk.dir_y ? i_walk.cur_y - 6'd1 : i_walk.cur_y + 6'd1;
        end
        o_step.nxt_err = sum[7:0];
    end

endmodule

FILE: src/glr_cell.sv
// ----------------------------------------------------------------------------
// glr_cell
// grid bounds check and linear index of one cell
// ----------------------------------------------------------------------------
module glr_cell (
    input  logic [5:0]    i_x,
    input  logic [5:0]    i_y,
    input  logic          i_last,
    input  glr_pkg::t_cfg i_cfg,
    output glr_pkg::t_cell o_cell
);
    import glr_pkg::*;

    logic [6:0]  cols_eff;
    logic [6:0]  rows_eff;
    logic        in_bounds;
    logic [12:0] prod;
    logic [12:0] idx;

    assign cols_eff  = (i_cfg.grid_cols > 7'(GRID_SIZE)) ? 7'(GRID_SIZE) : i_cfg.grid_cols;
    assign rows_eff  = (i_cfg.grid_rows > 7'(GRID_SIZE)) ? 7'(GRID_SIZE) : i_cfg.grid_rows;
    assign in_bounds = ({1'b0, i_x} < cols_eff) && ({1'b0, i_y} < rows_eff);
    assign prod      = 13'(i_y) * 13'(cols_eff);
    assign idx       = prod + 13'(i_x);

    assign o_cell.cell_x     = i_x;
    assign o_cell.cell_y     = i_y;
    assign o_cell.in_grid    = in_bounds;
    assign o_cell.cell_index = in_bounds ? idx[11:0] : 12'd0;
    assign o_cell.cell_color = i_cfg.paint_color;
    assign o_cell.last_cell  = i_last;

endmodule

FILE: src/grid_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// grid_line_rasterizer_top
// bresenham line walker over a cell grid, while walking one cell word per cycle
// ----------------------------------------------------------------------------
// channel   ports                                   handshake
// segment   i_segment                               start && !busy
// cell      o_result                                o_result_valid, no stall
// config    psel penable pwrite paddr pwdata prdata pready always high
//
// a segment is loaded in the idle state, then walked one cell per cycle
// through the shared step unit; busy is high for the whole walk; the
// last word leaves the cycle busy drops, so the next segment can start
// then; reset clears the sequencer and loads the register defaults
// ----------------------------------------------------------------------------
module grid_line_rasterizer_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  glr_pkg::t_segment i_segment,
    output logic              o_result_valid,
    output glr_pkg::t_cell    o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import glr_pkg::*;

    `include "grid_line_rasterizer_top_assert.svh"

    t_state            r_state;
    t_walk             r_walk;
    logic [5:0]        r_goal_x;
    logic [5:0]        r_goal_y;
    t_cell             r_result;
    logic              r_result_valid;
    t_cfg              cfg;
    t_step             step;
    t_cell             cell_word;
    logic              accept;
    logic              at_goal;
    logic [5:0]        dx;
    logic [5:0]        dy;

    glr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    glr_step u_step (
        .i_walk (r_walk),
        .o_step (step)
    );

    glr_cell u_cell (
        .i_x    (r_walk.cur_x),
        .i_y    (r_walk.cur_y),
        .i_last (at_goal),
        .i_cfg  (cfg),
        .o_cell (cell_word)
    );

    assign pready  = 1'b1;
    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign at_goal = (r_walk.cur_x == r_goal_x) && (r_walk.cur_y == r_goal_y);
    assign dx = (i_segment.end_x >= i_segment.start_x) ?
                i_segment.end_x - i_segment.start_x : i_segment.start_x - i_segment.end_x;
    assign dy = (i_segment.end_y >= i_segment.start_y) ?
                i_segment.end_y - i_segment.start_y : i_segment.start_y - i_segment.end_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_result_valid <= 1'b0;
            r_walk         <= '0;
            r_goal_x       <= '0;
            r_goal_y       <= '0;
        end else begin
            r_result_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_walk.cur_x   <= i_segment.start_x;
                        r_walk.cur_y   <= i_segment.start_y;
                        r_walk.span_dx <= {1'b0, dx};
                        r_walk.span_dy <= {1'b0, dy};
                        r_walk.err     <= $signed({2'b00, dx}) - $signed({2'b00, dy});
                        r_walk.dir_x   <= !(i_segment.start_x < i_segment.end_x);
                        r_walk.dir_y   <= !(i_segment.start_y < i_segment.end_y);
                        r_goal_x       <= i_segment.end_x;
                        r_goal_y       <= i_segment.end_y;
                        r_state        <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    r_result_valid <= 1'b1;
                    if (at_goal) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_walk.cur_x <= step.nxt_x;
                        r_walk.cur_y <= step.nxt_y;
                        r_walk.err   <= step.nxt_err;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WALK) begin
            r_result <= cell_word;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

    `GLR_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted segment did not raise busy")
    `GLR_ASSERT_NOW(a_mid_busy, o_result_valid && !o_result.last_cell, busy,
        "walk stopped before the end cell")
    `GLR_ASSERT_NOW(a_last_idle, o_result_valid && o_result.last_cell, !busy,
        "walk went on past the end cell")

endmodule

FILE: dv/tb_grid_line_rasterizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_line_rasterizer_top
// self-checking bench for the bresenham grid line walker
// ----------------------------------------------------------------------------
// segments go in through the start/busy handshake; every cell word that comes
// out is checked against cells worked out here by an all-octant bresenham
// walk under the current grid size and color. directed segments cover the
// corners, four octants, single-cell segments and the grid size extremes,
// then random segments run under changing grid settings and sender gaps
// ----------------------------------------------------------------------------
module tb_grid_line_rasterizer_top;
    import glr_pkg::*;

    localparam logic [1:0] REG_NONE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_segment    i_segment;
    logic        o_result_valid;
    t_cell       o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [6:0]  cols_cfg;
    logic [6:0]  rows_cfg;
    logic [31:0] color_cfg;
    t_cell       cell_queue[$];
    int          error_count = 0;
    int          idle_pct = 0;

    grid_line_rasterizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_segment     (i_segment),
        .o_result_valid(o_result_valid),
        .o_result      (o_result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void queue_segment_cells(t_segment seg);
        int    x;
        int    y;
        int    x1;
        int    y1;
        int    dx;
        int    dy;
        int    sx;
        int    sy;
        int    err;
        int    e2;
        int    cols;
        int    rows;
        bit    done;
        t_cell c;
        x = seg.start_x;
        y = seg.start_y;
        x1 = seg.end_x;
        y1 = seg.end_y;
        dx = (x1 >= x) ? x1 - x : x - x1;
        dy = (y1 >= y) ? y1 - y : y - y1;
        sx = (x < x1) ? 1 : -1;
        sy = (y < y1) ? 1 : -1;
        err = dx - dy;
        cols = (cols_cfg > GRID_SIZE) ? GRID_SIZE : int'(cols_cfg);
        rows = (rows_cfg > GRID_SIZE) ? GRID_SIZE : int'(rows_cfg);
        for (int n = 0; n < 64; n++) begin
            done = (x == x1) && (y == y1);
            c.cell_x = x[5:0];
            c.cell_y = y[5:0];
            c.in_grid = (x < cols) && (y < rows);
            c.cell_index = c.in_grid ? 12'((y * cols + x) & 12'hFFF) : 12'd0;
            c.cell_color = color_cfg;
            c.last_cell = done;
            cell_queue = {cell_queue, c};
            if (done) break;
            e2 = 2 * err;
            if (e2 >= -dy) begin
                err -= dy;
                x += sx;
            end
            if (e2 <= dx) begin
                err += dx;
                y += sy;
            end
        end
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cell want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (cell_queue.size() == 0) begin
                $error("cell word with nothing expected: x %0d y %0d",
                       o_result.cell_x, o_result.cell_y);
                error_count++;
            end else begin
                want = cell_queue.pop_front();
                check_field("cell_x", 32'(want.cell_x), 32'(o_result.cell_x));
                check_field("cell_y", 32'(want.cell_y), 32'(o_result.cell_y));
                check_field("in_grid", 32'(want.in_grid), 32'(o_result.in_grid));
                check_field("cell_index", 32'(want.cell_index), 32'(o_result.cell_index));
                check_field("cell_color", want.cell_color, o_result.cell_color);
                check_field("last_cell", 32'(want.last_cell), 32'(o_result.last_cell));
            end
        end
    end

    task automatic send_segment(t_segment seg);
        int gap;
        gap = 0;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 6);
        @(negedge i_clk);
        repeat (gap) @(negedge i_clk);
        start <= 1'b1;
        i_segment <= seg;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        queue_segment_cells(seg);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic send_xy(int sx0, int sy0, int ex0, int ey0);
        t_segment seg;
        seg.start_x = sx0[5:0];
        seg.start_y = sy0[5:0];
        seg.end_x = ex0[5:0];
        seg.end_y = ey0[5:0];
        send_segment(seg);
    endtask

    task automatic wait_cells_drained();
        while (cell_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        wait_cells_drained();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        case (idx)
            REG_GRID_COLS:   cols_cfg = data[6:0];
            REG_GRID_ROWS:   rows_cfg = data[6:0];
            REG_PAINT_COLOR: color_cfg = data;
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_grid(logic [6:0] cols, logic [6:0] rows, logic [31:0] color);
        write_reg(REG_GRID_COLS, {25'd0, cols});
        write_reg(REG_GRID_ROWS, {25'd0, rows});
        write_reg(REG_PAINT_COLOR, color);
    endtask

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : (v > 63) ? 63 : v;
    endfunction

    function automatic t_segment pick_segment();
        t_segment seg;
        int       kind;
        seg = t_segment'(24'($urandom));
        kind = $urandom_range(0, 9);
        case (kind)
            4, 5: begin
                seg.end_x = 6'(clamp_coord(int'(seg.start_x) + $urandom_range(0, 6) - 3));
                seg.end_y = 6'(clamp_coord(int'(seg.start_y) + $urandom_range(0, 6) - 3));
            end
            6: seg.end_y = seg.start_y;
            7: seg.end_x = seg.start_x;
            8: seg.end_y = 6'(clamp_coord(int'(seg.start_y)
                           + (($urandom_range(0, 1) == 1) ? 1 : -1)
                           * int'((seg.end_x > seg.start_x) ? seg.end_x - seg.start_x
                                                             : seg.start_x - seg.end_x)));
            9: begin
                seg.end_x = seg.start_x;
                seg.end_y = seg.start_y;
            end
            default: ;
        endcase
        return seg;
    endfunction

    task automatic test_octants();
        send_xy(0, 0, 0, 0);
        send_xy(63, 63, 63, 63);
        send_xy(0, 0, 63, 63);
        send_xy(63, 0, 0, 63);
        send_xy(0, 63, 63, 0);
        send_xy(63, 63, 0, 0);
        send_xy(0, 5, 63, 5);
        send_xy(63, 40, 0, 40);
        send_xy(7, 0, 7, 63);
        send_xy(50, 63, 50, 0);
        send_xy(10, 0, 20, 63);
        send_xy(20, 63, 10, 0);
        send_xy(0, 10, 63, 20);
        send_xy(63, 20, 0, 10);
        send_xy(5, 5, 6, 7);
    endtask

    task automatic test_grid_limits();
        // no column in use
        set_grid(7'd0, 7'd64, 32'h0000_0000);
        send_xy(0, 0, 20, 63);
        // oversized columns and rows saturate
        set_grid(7'd127, 7'd100, 32'hFFFF_FFFF);
        send_xy(63, 0, 0, 63);
        send_xy(0, 63, 63, 63);
        // single cell grid
        set_grid(7'd1, 7'd1, 32'h5A5A_A5A5);
        send_xy(0, 0, 3, 2);
        send_xy(2, 3, 0, 0);
        set_grid(7'd64, 7'd0, 32'hA5A5_5A5A);
        send_xy(40, 0, 0, 10);
    endtask

    task automatic test_bad_register();
        set_grid(7'd33, 7'd17, 32'h1234_5678);
        // write outside the register map must leave every register alone
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        send_xy(0, 0, 63, 30);
        send_xy(32, 16, 33, 17);
    endtask

    task automatic test_random_walks();
        int phase_pct[3];
        phase_pct = '{16, 56, 0};
        for (int p = 0; p < 3; p++) begin
            idle_pct = phase_pct[p];
            for (int i = 0; i < 145; i++) begin
                if (i % 48 == 0) begin
                    case ($urandom_range(0, 3))
                        0: set_grid(7'd64, 7'd64, $urandom);
                        1: set_grid(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                    $urandom);
                        default: set_grid(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                                          $urandom);
                    endcase
                end
                if (i == 70) wait_cells_drained();
                send_segment(pick_segment());
            end
        end
        idle_pct = 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_segment = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cols_cfg = GRID_COLS_RST;
        rows_cfg = GRID_ROWS_RST;
        color_cfg = PAINT_COLOR_RST;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_octants();
        test_grid_limits();
        test_bad_register();
        test_random_walks();

        wait_cells_drained();
        repeat (70) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/glr_pkg.sv
src/glr_cfg.sv
src/glr_step.sv
src/glr_cell.sv
src/grid_line_rasterizer_top.sv
dv/tb_grid_line_rasterizer_top.sv
